>>> rtl/integer_literal_parser_macros.svh
// ----------------------------------------------------------------------------
// integer_literal_parser_macros
// Assertion helpers for the integer literal parser RTL.
// ----------------------------------------------------------------------------
`ifndef INTEGER_LITERAL_PARSER_MACROS_SVH
`define INTEGER_LITERAL_PARSER_MACROS_SVH

// same-cycle implication, held off while reset is high
`define ILP_ASSERT_IMPLY(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error(msg);

// next-cycle implication, held off while reset is high
`define ILP_ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error(msg);

`endif

>>> rtl/ilp_pkg.sv
// ----------------------------------------------------------------------------
// ilp_pkg
// Types, character codes and radix helpers for the integer literal parser.
// ----------------------------------------------------------------------------
package ilp_pkg;

   typedef enum logic [2:0] {
      PH_START,
      PH_SIGN,
      PH_ZERO,
      PH_PREFIX,
      PH_DIGITS
   } phase_type;

   typedef enum logic [1:0] {
      RX_DEC,
      RX_BIN,
      RX_OCT,
      RX_HEX
   } radix_type;

   typedef struct packed {
      logic is_digit;
      logic carry;
   } digit_status_type;

   localparam logic [7:0] CH_ZERO    = 8'h30;
   localparam logic [7:0] CH_ONE     = 8'h31;
   localparam logic [7:0] CH_NINE    = 8'h39;
   localparam logic [7:0] CH_MINUS   = 8'h2d;
   localparam logic [7:0] CH_LOWER_A = 8'h61;
   localparam logic [7:0] CH_LOWER_B = 8'h62;
   localparam logic [7:0] CH_LOWER_F = 8'h66;
   localparam logic [7:0] CH_LOWER_X = 8'h78;
   localparam logic [7:0] HEX_LETTER_OFFSET = 8'd10;

   function automatic logic [4:0] radix_base(radix_type radix);
      logic [4:0] base;
      unique case (radix)
         RX_BIN:  base = 5'd2;
         RX_OCT:  base = 5'd8;
         RX_HEX:  base = 5'd16;
         default: base = 5'd10;
      endcase
      return base;
   endfunction

endpackage

>>> rtl/integer_literal_parser.sv
// An accepted character is registered, then a last one loads the result register.
// Throughput: one character per cycle; a result waiting on rsp_ready stalls
// only a last character, ordinary characters keep flowing into the parse state.
// Reset (synchronous, active high): parse state back to start of literal,
// allow_minus set, both pipeline registers empty.
// ----------------------------------------------------------------------------
// integer_literal_parser
// Streaming parser of C-style integer literals (sign, 0b, 0x, octal, decimal).
// ----------------------------------------------------------------------------
`include "integer_literal_parser_macros.svh"

module integer_literal_parser #(
   parameter int VALUE_WIDTH = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_char_code,
   input  logic        req_last,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_value,
   output logic        rsp_valid_res,
   output logic        rsp_overflow,
   input  logic        csr_we,
   input  logic        csr_wdata
);
   import ilp_pkg::*;

   logic                   allow_minus_ff;
   logic                   in_valid_ff, in_valid_in;
   logic [7:0]             in_char_ff;
   logic                   in_last_ff;
   logic                   adv;

   phase_type              phase_ff, phase_in;
   radix_type              radix_ff, radix_in;
   logic [VALUE_WIDTH-1:0] acc_ff, acc_in;
   logic [VALUE_WIDTH-1:0] nacc_ff, nacc_in;
   logic                   neg_ff, neg_in;
   logic                   seen_ff, seen_in;
   logic                   bad_ff, bad_in;
   logic                   wrap_ff, wrap_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [63:0]            rsp_value_ff, rsp_value_in;
   logic                   rsp_valid_res_ff, rsp_valid_res_in;
   logic                   rsp_overflow_ff, rsp_overflow_in;

   logic [VALUE_WIDTH-1:0] du_acc, du_nacc;
   digit_status_type       du_status;
   logic                   ok;

   ilp_digit_unit #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_digit (
      .char_code (in_char_ff),
      .radix     (radix_ff),
      .acc       (acc_ff),
      .nacc      (nacc_ff),
      .acc_next  (du_acc),
      .nacc_next (du_nacc),
      .status    (du_status)
   );

   assign adv         = in_valid_ff && (!in_last_ff || !rsp_valid_ff || rsp_ready);
   assign req_ready   = !in_valid_ff || adv;
   assign in_valid_in = req_valid ? 1'b1 : (in_valid_ff && !adv);

   always_comb begin
      phase_in = phase_ff;
      radix_in = radix_ff;
      acc_in   = acc_ff;
      nacc_in  = nacc_ff;
      neg_in   = neg_ff;
      seen_in  = seen_ff;
      bad_in   = bad_ff;
      wrap_in  = wrap_ff;
      if (adv && !bad_ff) begin
         unique case (phase_ff)
            PH_START, PH_SIGN: begin
               if (in_char_ff == CH_MINUS && phase_ff == PH_START && allow_minus_ff) begin
                  neg_in   = 1'b1;
                  phase_in = PH_SIGN;
               end else if (in_char_ff == CH_ZERO) begin
                  radix_in = RX_OCT;
                  acc_in   = '0;
                  nacc_in  = '0;
                  seen_in  = 1'b1;
                  phase_in = PH_ZERO;
               end else if (in_char_ff >= CH_ONE && in_char_ff <= CH_NINE) begin
                  // radix is still decimal and acc zero here
                  radix_in = RX_DEC;
                  acc_in   = du_acc;
                  nacc_in  = du_nacc;
                  seen_in  = 1'b1;
                  phase_in = PH_DIGITS;
               end else begin
                  bad_in = 1'b1;
               end
            end
            PH_ZERO: begin
               if (in_char_ff == CH_LOWER_B || in_char_ff == CH_LOWER_X) begin
                  radix_in = (in_char_ff == CH_LOWER_B) ? RX_BIN : RX_HEX;
                  acc_in   = '0;
                  nacc_in  = '0;
                  seen_in  = 1'b0;
                  phase_in = PH_PREFIX;
               end else if (du_status.is_digit) begin
                  acc_in   = du_acc;
                  nacc_in  = du_nacc;
                  wrap_in  = wrap_ff | du_status.carry;
                  seen_in  = 1'b1;
                  phase_in = PH_DIGITS;
               end else begin
                  bad_in = 1'b1;
               end
            end
            default: begin
               if (du_status.is_digit) begin
                  acc_in   = du_acc;
                  nacc_in  = du_nacc;
                  wrap_in  = wrap_ff | du_status.carry;
                  seen_in  = 1'b1;
                  phase_in = PH_DIGITS;
               end else begin
                  bad_in = 1'b1;
               end
            end
         endcase
      end

      ok               = !bad_in && seen_in;
      rsp_value_in     = ok ? 64'(neg_in ? nacc_in : acc_in) : 64'd0;
      rsp_valid_res_in = ok;
      rsp_overflow_in  = ok && wrap_in;
      rsp_valid_in     = (adv && in_last_ff) ? 1'b1 : (rsp_valid_ff && !rsp_ready);

      if (adv && in_last_ff) begin
         phase_in = PH_START;
         radix_in = RX_DEC;
         acc_in   = '0;
         nacc_in  = '0;
         neg_in   = 1'b0;
         seen_in  = 1'b0;
         bad_in   = 1'b0;
         wrap_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         allow_minus_ff <= 1'b1;
         in_valid_ff    <= 1'b0;
         phase_ff       <= PH_START;
         radix_ff       <= RX_DEC;
         acc_ff         <= '0;
         nacc_ff        <= '0;
         neg_ff         <= 1'b0;
         seen_ff        <= 1'b0;
         bad_ff         <= 1'b0;
         wrap_ff        <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_we) begin
            allow_minus_ff <= csr_wdata;
         end
         in_valid_ff  <= in_valid_in;
         phase_ff     <= phase_in;
         radix_ff     <= radix_in;
         acc_ff       <= acc_in;
         nacc_ff      <= nacc_in;
         neg_ff       <= neg_in;
         seen_ff      <= seen_in;
         bad_ff       <= bad_in;
         wrap_ff      <= wrap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (req_valid && req_ready) begin
         in_char_ff <= req_char_code;
         in_last_ff <= req_last;
      end
      if (adv && in_last_ff) begin
         rsp_value_ff     <= rsp_value_in;
         rsp_valid_res_ff <= rsp_valid_res_in;
         rsp_overflow_ff  <= rsp_overflow_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_value     = rsp_value_ff;
   assign rsp_valid_res = rsp_valid_res_ff;
   assign rsp_overflow  = rsp_overflow_ff;

   `ILP_ASSERT_IMPLY(a_ovf_needs_valid, clock, reset, rsp_valid_ff && rsp_overflow_ff,
      rsp_valid_res_ff, "overflow on a malformed word")
   `ILP_ASSERT_IMPLY(a_bad_value_zero, clock, reset, rsp_valid_ff && !rsp_valid_res_ff,
      rsp_value_ff == 64'd0, "malformed word with nonzero value")
   `ILP_ASSERT_NEXT(a_clear_after_last, clock, reset, adv && in_last_ff,
      phase_ff == PH_START && acc_ff == '0 && !neg_ff && !wrap_ff,
      "parse state not cleared after last")
   `ILP_ASSERT_IMPLY(a_neg_tracks_acc, clock, reset, 1'b1,
      VALUE_WIDTH'(acc_ff + nacc_ff) == '0, "negated value out of step")

endmodule

>>> rtl/ilp_digit_unit.sv
// ----------------------------------------------------------------------------
// ilp_digit_unit
// Decodes one character as a digit of the current radix and folds it into
// the magnitude and the negated value (acc*base + d, -acc*base - d).
// ----------------------------------------------------------------------------
module ilp_digit_unit #(
   parameter int VALUE_WIDTH = 64
) (
   input  logic [7:0]                  char_code,
   input  ilp_pkg::radix_type          radix,
   input  logic [VALUE_WIDTH-1:0]      acc,
   input  logic [VALUE_WIDTH-1:0]      nacc,
   output logic [VALUE_WIDTH-1:0]      acc_next,
   output logic [VALUE_WIDTH-1:0]      nacc_next,
   output ilp_pkg::digit_status_type   status
);
   import ilp_pkg::*;

   localparam int EXT_WIDTH = VALUE_WIDTH + 4;

   logic                 is_dec;
   logic                 is_hex;
   logic [3:0]           digit;
   logic [EXT_WIDTH-1:0] acc_ext;
   logic [EXT_WIDTH-1:0] prod;
   logic [EXT_WIDTH-1:0] sum;
   logic [VALUE_WIDTH-1:0] nprod;

   assign is_dec = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
   assign is_hex = (radix == RX_HEX) && (char_code >= CH_LOWER_A) &&
                   (char_code <= CH_LOWER_F);
   assign digit  = is_dec ? 4'(char_code - CH_ZERO)
                          : 4'(char_code - CH_LOWER_A + HEX_LETTER_OFFSET);
   assign acc_ext = EXT_WIDTH'(acc);

   always_comb begin
      unique case (radix)
         RX_BIN: begin
            prod  = acc_ext << 1;
            nprod = nacc << 1;
         end
         RX_OCT: begin
            prod  = acc_ext << 3;
            nprod = nacc << 3;
         end
         RX_HEX: begin
            prod  = acc_ext << 4;
            nprod = nacc << 4;
         end
         default: begin
            prod  = (acc_ext << 3) + (acc_ext << 1);
            nprod = (nacc << 3) + (nacc << 1);
         end
      endcase
   end

   assign sum       = prod + EXT_WIDTH'(digit);
   assign acc_next  = sum[VALUE_WIDTH-1:0];
   assign nacc_next = nprod - VALUE_WIDTH'(digit);

   assign status.is_digit = (is_dec || is_hex) && (5'(digit) < radix_base(radix));
   assign status.carry    = |sum[EXT_WIDTH-1:VALUE_WIDTH];

endmodule

>>> sim/integer_literal_parser_checker.sv
// ----------------------------------------------------------------------------
// integer_literal_parser_checker
// Watches the character and result channels and the allow_minus write port,
// keeps its own parse state, and compares each returned result word with the
// oldest one it predicted. Failures and outstanding results go to the top.
// ----------------------------------------------------------------------------
module integer_literal_parser_checker #(
   parameter int VALUE_WIDTH = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [7:0]  req_char_code,
   input  logic        req_last,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [63:0] rsp_value,
   input  logic        rsp_valid_res,
   input  logic        rsp_overflow,
   input  logic        csr_we,
   input  logic        csr_wdata,
   output int          fail_total,
   output int          outstanding
);
   import ilp_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [4:0] NO_DIGIT = 5'd16;

   typedef struct packed {
      logic [63:0] value;
      logic        valid_res;
      logic        overflow;
   } literal_result_type;

   literal_result_type literal_results_q[$];

   logic                   allow_minus;
   phase_type              phase;
   radix_type              radix;
   logic [VALUE_WIDTH-1:0] magnitude;
   logic                   negative;
   logic                   seen_digit;
   logic                   malformed;
   logic                   wrapped;
   int                     mismatches = 0;

   function automatic logic [4:0] radix_weight(radix_type r);
      case (r)
         RX_BIN:  return 5'd2;
         RX_OCT:  return 5'd8;
         RX_HEX:  return 5'd16;
         default: return 5'd10;
      endcase
   endfunction

   function automatic logic [4:0] digit_value(logic [7:0] ch, radix_type r);
      logic [4:0] d;
      if (ch >= CH_ZERO && ch <= CH_NINE) begin
         d = 5'(ch - CH_ZERO);
      end else if (r == RX_HEX && ch >= CH_LOWER_A && ch <= CH_LOWER_F) begin
         d = 5'(ch - CH_LOWER_A + HEX_LETTER_OFFSET);
      end else begin
         return NO_DIGIT;
      end
      return (d < radix_weight(r)) ? d : NO_DIGIT;
   endfunction

   function void restart_literal();
      phase      = PH_START;
      radix      = RX_DEC;
      magnitude  = '0;
      negative   = 1'b0;
      seen_digit = 1'b0;
      malformed  = 1'b0;
      wrapped    = 1'b0;
   endfunction

   function void shift_in(logic [4:0] d);
      logic [VALUE_WIDTH+4:0] widened;
      widened = magnitude * radix_weight(radix) + d;
      if (widened[VALUE_WIDTH+4:VALUE_WIDTH] != '0) begin
         wrapped = 1'b1;
      end
      magnitude  = widened[VALUE_WIDTH-1:0];
      seen_digit = 1'b1;
   endfunction

   function void take_digit_char(logic [7:0] ch);
      logic [4:0] d;
      d = digit_value(ch, radix);
      if (d == NO_DIGIT) begin
         malformed = 1'b1;
      end else begin
         shift_in(d);
         phase = PH_DIGITS;
      end
   endfunction

   function void parse_char(logic [7:0] ch);
      if (malformed) begin
         return;
      end
      case (phase)
         PH_START, PH_SIGN: begin
            if (ch == CH_MINUS && phase == PH_START && allow_minus) begin
               negative = 1'b1;
               phase    = PH_SIGN;
            end else if (ch == CH_ZERO) begin
               radix = RX_OCT;
               shift_in(5'd0);
               phase = PH_ZERO;
            end else if (ch >= CH_ONE && ch <= CH_NINE) begin
               radix = RX_DEC;
               shift_in(5'(ch - CH_ZERO));
               phase = PH_DIGITS;
            end else begin
               malformed = 1'b1;
            end
         end
         PH_ZERO: begin
            if (ch == CH_LOWER_B || ch == CH_LOWER_X) begin
               radix      = (ch == CH_LOWER_B) ? RX_BIN : RX_HEX;
               magnitude  = '0;
               seen_digit = 1'b0;
               phase      = PH_PREFIX;
            end else begin
               take_digit_char(ch);
            end
         end
         default: take_digit_char(ch);
      endcase
   endfunction

   function literal_result_type close_literal();
      literal_result_type res;
      logic [VALUE_WIDTH-1:0] bits;
      res = '0;
      if (!malformed && seen_digit) begin
         bits          = negative ? (~magnitude + 1'b1) : magnitude;
         res.value     = 64'(bits);
         res.valid_res = 1'b1;
         res.overflow  = wrapped;
      end
      restart_literal();
      return res;
   endfunction

   function void note(string what, logic [63:0] want, logic [63:0] got);
      mismatches++;
      if (mismatches <= 10) begin
         $display("%0t mismatch %s: expected %0h, got %0h", $realtime, what, want, got);
      end
   endfunction

   always @(posedge clock) begin : watch
      literal_result_type got;
      literal_result_type want;
      if (reset) begin
         allow_minus = 1'b1;
         restart_literal();
         literal_results_q.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_value, rsp_valid_res, rsp_overflow};
            if (literal_results_q.size() == 0) begin
               note("unexpected result word", '0, got.value);
            end else begin
               want = literal_results_q.pop_front();
               if (got.value !== want.value)
                  note("value", want.value, got.value);
               if (got.valid_res !== want.valid_res)
                  note("valid_res", 64'(want.valid_res), 64'(got.valid_res));
               if (got.overflow !== want.overflow)
                  note("overflow", 64'(want.overflow), 64'(got.overflow));
            end
         end
         if (req_valid && req_ready) begin
            parse_char(req_char_code);
            if (req_last) begin
               literal_results_q.push_back(close_literal());
            end
         end
         if (csr_we) begin
            allow_minus = csr_wdata;
         end
      end
      fail_total  <= mismatches;
      outstanding <= literal_results_q.size();
   end

endmodule

>>> sim/integer_literal_parser_tb.sv
// ----------------------------------------------------------------------------
// integer_literal_parser_tb
// Drives character words into the parser with random gaps and result-side
// stalls: a directed set of edge-case literals, then random literals (mostly
// well formed, some broken or pure noise) across allow_minus settings.
// ----------------------------------------------------------------------------
module integer_literal_parser_tb;
   import ilp_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int         HALF_PERIOD = 6;
   localparam int         VALUE_WIDTH = 64;
   localparam logic [7:0] CASE_BIT    = 8'h20;

   logic        clock         = 1'b0;
   logic        reset         = 1'b1;
   logic        req_valid     = 1'b0;
   logic        req_ready;
   logic [7:0]  req_char_code = '0;
   logic        req_last      = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready     = 1'b1;
   logic [63:0] rsp_value;
   logic        rsp_valid_res;
   logic        rsp_overflow;
   logic        csr_we        = 1'b0;
   logic        csr_wdata     = 1'b0;

   logic        quiet = 1'b0;
   logic        calm  = 1'b0;
   int          stall_left = 0;
   int          fail_total;
   int          outstanding;
   logic [7:0]  literal_chars[$];

   always #(HALF_PERIOD) clock = ~clock;

   integer_literal_parser #(
      .VALUE_WIDTH(VALUE_WIDTH)
   ) u_top (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_char_code (req_char_code),
      .req_last      (req_last),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_value     (rsp_value),
      .rsp_valid_res (rsp_valid_res),
      .rsp_overflow  (rsp_overflow),
      .csr_we        (csr_we),
      .csr_wdata     (csr_wdata)
   );

   integer_literal_parser_checker #(
      .VALUE_WIDTH(VALUE_WIDTH)
   ) u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_char_code (req_char_code),
      .req_last      (req_last),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_value     (rsp_value),
      .rsp_valid_res (rsp_valid_res),
      .rsp_overflow  (rsp_overflow),
      .csr_we        (csr_we),
      .csr_wdata     (csr_wdata),
      .fail_total    (fail_total),
      .outstanding   (outstanding)
   );

   // result-side back-pressure in random bursts
   always @(posedge clock) begin
      if (reset || quiet || calm) begin
         rsp_ready  <= 1'b1;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 4) == 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= $urandom_range(0, 2);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   task automatic send_char(input logic [7:0] ch, input logic fin);
      if (!quiet && !calm && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_char_code <= ch;
      req_last      <= fin;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) begin
         send_char(s[i], i == s.len() - 1);
      end
   endtask

   function automatic logic [7:0] digit_char(int base, logic all_max);
      int d;
      d = all_max ? base - 1 : $urandom_range(0, base - 1);
      return (d < 10) ? 8'(CH_ZERO + d) : 8'(CH_LOWER_A + d - 10);
   endfunction

   function automatic void make_literal();
      radix_type form;
      int        n;
      int        k;
      logic      all_max;
      literal_chars.delete();
      form    = radix_type'($urandom_range(0, 3));
      all_max = ($urandom_range(0, 3) == 0);
      n       = ($urandom_range(0, 7) == 0) ? $urandom_range(12, 24) : $urandom_range(1, 5);
      if ($urandom_range(0, 9) == 0) begin
         repeat ($urandom_range(1, 4)) literal_chars.push_back(8'($urandom_range(0, 255)));
         return;
      end
      if ($urandom_range(0, 3) == 0) begin
         literal_chars.push_back(CH_MINUS);
      end
      case (form)
         RX_BIN: begin
            literal_chars.push_back(CH_ZERO);
            literal_chars.push_back(CH_LOWER_B);
            repeat (3 * n) literal_chars.push_back(digit_char(2, all_max));
         end
         RX_HEX: begin
            literal_chars.push_back(CH_ZERO);
            literal_chars.push_back(CH_LOWER_X);
            repeat (n) literal_chars.push_back(digit_char(16, all_max));
         end
         RX_OCT: begin
            literal_chars.push_back(CH_ZERO);
            repeat (n - 1) literal_chars.push_back(digit_char(8, all_max));
         end
         default: begin
            literal_chars.push_back(all_max ? CH_NINE : 8'(CH_ONE + $urandom_range(0, 8)));
            repeat (n - 1) literal_chars.push_back(digit_char(10, all_max));
         end
      endcase
      // break about one literal in four
      if ($urandom_range(0, 3) == 0) begin
         k = $urandom_range(0, literal_chars.size() - 1);
         case ($urandom_range(0, 3))
            0: literal_chars[k] = 8'($urandom_range(0, 255));
            1: while (literal_chars.size() > k + 1) void'(literal_chars.pop_back());
            2: literal_chars.insert(k, CH_MINUS);
            default: begin
               if (literal_chars[k] >= CH_LOWER_A && literal_chars[k] <= CH_LOWER_X)
                  literal_chars[k] = literal_chars[k] ^ CASE_BIT;
               else
                  literal_chars[k] = 8'($urandom_range(0, 255));
            end
         endcase
      end
   endfunction

   task automatic run_random(input int budget);
      int sent;
      sent = 0;
      while (sent < budget) begin
         make_literal();
         calm <= ($urandom_range(0, 4) == 0);
         for (int i = 0; i < literal_chars.size(); i++) begin
            send_char(literal_chars[i], i == literal_chars.size() - 1);
         end
         sent += literal_chars.size();
      end
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic write_allow_minus(input logic v);
      csr_we    <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   initial begin : stimulus
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      send_text("0");
      send_text("00");
      send_text("-9");
      send_text("0xf");
      send_text("0b1");
      send_text("-");
      send_text("0b");
      send_text("-0x");
      send_text("08");
      send_text("0X1");
      send_text("0xA");
      send_text("--1");
      send_text("1-");
      send_char(8'h00, 1'b1);
      send_char(8'hff, 1'b1);
      run_random(100);

      settle();
      write_allow_minus(1'b0);
      run_random(100);

      settle();
      write_allow_minus(1'b1);
      run_random(100);

      settle();
      write_allow_minus(1'b0);
      quiet <= 1'b1;
      run_random(100);

      settle();
      if (fail_total == 0 && outstanding == 0) begin
         $display("** integer_literal_parser: PASSED **");
      end else begin
         $display("** integer_literal_parser: FAILED **");
      end
      $finish;
   end

   initial begin : watchdog
      #2_000_000;
      $display("** integer_literal_parser: FAILED **");
      $finish;
   end

endmodule
